// ===== src/mrtu_pkg.sv =====
// Shared constants, types and codes for the Modbus RTU frame receiver.
package mrtu_pkg;

	localparam int MAX_BUFFER = 4096;
	localparam int FILL_W     = $clog2(MAX_BUFFER + 1);
	localparam int IDX_W      = 12;
	localparam int HDR_N      = 6;
	localparam int HDR_AW     = 3;
	localparam int LEN_SHORT  = 5;
	localparam int LEN_FIXED  = 8;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = 2;

	localparam logic [7:0]  FC_EXC_MASK   = 8'h80;
	localparam logic [7:0]  FC_READ_FIRST = 8'h01;
	localparam logic [7:0]  FC_READ_LAST  = 8'h04;
	localparam logic [7:0]  FC_WRITE_COIL = 8'h05;
	localparam logic [7:0]  FC_WRITE_REG  = 8'h06;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;

	typedef enum logic [1:0] {
		ST_IN_FRAME = 2'd0,
		ST_GOOD     = 2'd1,
		ST_CRC_BAD  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_PLAIN = 2'd0,
		KIND_EXC   = 2'd1,
		KIND_READ  = 2'd2,
		KIND_ADDR  = 2'd3
	} kind_t;

	// one classified item on its way from the front to the back
	typedef struct packed {
		logic [7:0]             data_byte;
		logic [IDX_W-1:0]       byte_index;
		logic                   frame_end;
		status_t                status;
		logic [HDR_N-1:0][7:0]  hdr;
		logic                   len8;
	} rec_t;

endpackage

// ===== src/modbus_rtu_frame_receiver.sv =====
// Top level of the Modbus RTU frame receiver: front end, item queue and back end.
//
//  channel   direction  handshake          payload
//  input     in         push / full        rx_byte
//  result    out        empty / pop        data_byte, byte_index, frame_end, status,
//                                          slave_id, function_code, frame_kind,
//                                          detail_byte, reg_address, reg_value
//
// One item per cycle sustained while pop keeps the output drained; every item gives exactly one result.
// An accepted item goes into a queue entry, then into the output register once that register is free.
// The front does the CRC byte update and length check in the accept cycle.
// A four-entry queue and the output register absorb up to five items while pop is low.
// arst_n clears frame fill, header bytes, queue and output valid; CRC goes to CRC_INIT.
module modbus_rtu_frame_receiver import mrtu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [7:0]  rx_byte,
	output logic        full,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  data_byte,
	output logic [11:0] byte_index,
	output logic        frame_end,
	output logic [1:0]  status,
	output logic [7:0]  slave_id,
	output logic [7:0]  function_code,
	output logic [1:0]  frame_kind,
	output logic [7:0]  detail_byte,
	output logic [15:0] reg_address,
	output logic [15:0] reg_value
);

	logic q_full, q_empty, q_wr, q_rd;
	rec_t wr_rec, rd_rec;

	assign full = q_full;

	mrtu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.q_full  (q_full),
		.wr_en   (q_wr),
		.wr_rec  (wr_rec)
	);

	mrtu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr),
		.wr_rec (wr_rec),
		.rd_en  (q_rd),
		.rd_rec (rd_rec),
		.full   (q_full),
		.empty  (q_empty)
	);

	mrtu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_rec         (rd_rec),
		.q_rd          (q_rd),
		.pop           (pop),
		.empty         (empty),
		.data_byte     (data_byte),
		.byte_index    (byte_index),
		.frame_end     (frame_end),
		.status        (status),
		.slave_id      (slave_id),
		.function_code (function_code),
		.frame_kind    (frame_kind),
		.detail_byte   (detail_byte),
		.reg_address   (reg_address),
		.reg_value     (reg_value)
	);

endmodule

// ===== src/mrtu_front.sv =====
// Front end: frame fill, running CRC, header capture and frame-end classification.
module mrtu_front import mrtu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       wr_en,
	output rec_t       wr_rec
);

	logic [FILL_W-1:0]     fill_q;
	logic [15:0]           crc_q;
	logic [HDR_N-1:0][7:0] hdr_q;

	logic [FILL_W-1:0]     fill_n;
	logic [15:0]           crc_n;
	logic [HDR_N-1:0][7:0] hdr_n;
	logic                  ovf;
	logic                  done;
	logic                  crc_ok;
	logic [7:0]            fc;
	logic [7:0]            cnt;

	function automatic logic [15:0] crc_upd(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	assign wr_en  = push && !q_full;
	assign ovf    = fill_q >= FILL_W'(MAX_BUFFER);
	assign fill_n = fill_q + FILL_W'(1);
	assign crc_n  = crc_upd(crc_q, rx_byte);
	assign crc_ok = crc_n == 16'h0000;
	assign fc     = hdr_n[1];
	assign cnt    = hdr_n[2];

	always_comb begin
		hdr_n = hdr_q;
		if (fill_q < FILL_W'(HDR_N)) begin
			hdr_n[fill_q[HDR_AW-1:0]] = rx_byte;
		end
	end

	always_comb begin
		done = 1'b0;
		if (fill_n >= FILL_W'(LEN_SHORT)) begin
			if ((fc & FC_EXC_MASK) != 8'h00) begin
				done = fill_n == FILL_W'(LEN_SHORT);
			end else if (fc == FC_WRITE_COIL || fc == FC_WRITE_REG) begin
				done = fill_n == FILL_W'(LEN_FIXED);
			end else if (fc >= FC_READ_FIRST && fc <= FC_READ_LAST) begin
				// eight-byte request with a good CRC wins over the byte count
				done = (fill_n == FILL_W'(LEN_FIXED) && crc_ok) ||
				       (cnt != 8'h00 && fill_n == FILL_W'(cnt) + FILL_W'(LEN_SHORT));
			end else begin
				done = fill_n == FILL_W'(LEN_SHORT);
			end
		end
	end

	always_comb begin
		wr_rec            = '0;
		wr_rec.data_byte  = rx_byte;
		wr_rec.byte_index = fill_q[IDX_W-1:0];
		wr_rec.hdr        = hdr_n;
		wr_rec.len8       = fill_n == FILL_W'(LEN_FIXED);
		if (ovf) begin
			wr_rec.frame_end = 1'b1;
			wr_rec.status    = ST_OVERFLOW;
		end else if (done) begin
			wr_rec.frame_end = 1'b1;
			wr_rec.status    = crc_ok ? ST_GOOD : ST_CRC_BAD;
		end else begin
			wr_rec.status    = ST_IN_FRAME;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			crc_q  <= CRC_INIT;
			hdr_q  <= '0;
		end else if (wr_en) begin
			if (ovf || done) begin
				fill_q <= '0;
				crc_q  <= CRC_INIT;
			end else begin
				fill_q <= fill_n;
				crc_q  <= crc_n;
			end
			if (!ovf) begin
				hdr_q <= hdr_n;
			end
		end
	end

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_BUFFER))
		else $error("frame fill beyond buffer size");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr_rec.frame_end) |=> (fill_q == '0 && crc_q == CRC_INIT))
		else $error("frame not cleared after frame end");

	a_empty_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (crc_q == CRC_INIT))
		else $error("crc not at init on empty frame");
`endif

endmodule

// ===== src/mrtu_queue.sv =====
// Short register queue of classified items between front and back.
module mrtu_queue import mrtu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  rec_t wr_rec,
	input  logic rd_en,
	output rec_t rd_rec,
	output logic full,
	output logic empty
);

	rec_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q;
	logic [Q_AW-1:0] rp_q;
	logic [Q_AW:0]   cnt_q;

	assign full   = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign empty  = cnt_q == '0;
	assign rd_rec = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + Q_AW'(1);
			end
			if (rd_en) begin
				rp_q <= rp_q + Q_AW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + (Q_AW+1)'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - (Q_AW+1)'(1);
			end
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (Q_AW+1)'(Q_DEPTH))
		else $error("queue count beyond depth");

	a_no_wr_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr_en)
		else $error("write into full queue");

	a_no_rd_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !rd_en)
		else $error("read from empty queue");
`endif

endmodule

// ===== src/mrtu_back.sv =====
// Back end: decodes frame fields and holds the result output register.
module mrtu_back import mrtu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  rec_t        q_rec,
	output logic        q_rd,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  data_byte,
	output logic [11:0] byte_index,
	output logic        frame_end,
	output logic [1:0]  status,
	output logic [7:0]  slave_id,
	output logic [7:0]  function_code,
	output logic [1:0]  frame_kind,
	output logic [7:0]  detail_byte,
	output logic [15:0] reg_address,
	output logic [15:0] reg_value
);

	logic        out_valid_q;
	logic [7:0]  slave_n, fc_n, detail_n;
	logic [15:0] addr_n, value_n;
	kind_t       kind_n;
	logic [7:0]  fc;

	assign q_rd  = !q_empty && (!out_valid_q || pop);
	assign empty = !out_valid_q;
	assign fc    = q_rec.hdr[1];

	always_comb begin
		slave_n  = '0;
		fc_n     = '0;
		detail_n = '0;
		addr_n   = '0;
		value_n  = '0;
		kind_n   = KIND_PLAIN;
		if (q_rec.status == ST_GOOD) begin
			slave_n = q_rec.hdr[0];
			fc_n    = fc;
			if ((fc & FC_EXC_MASK) != 8'h00) begin
				kind_n   = KIND_EXC;
				detail_n = q_rec.hdr[2];
			end else if (fc >= FC_READ_FIRST && fc <= FC_READ_LAST) begin
				kind_n   = KIND_READ;
				detail_n = q_rec.hdr[2];
			end else if (q_rec.len8) begin
				kind_n  = KIND_ADDR;
				addr_n  = {q_rec.hdr[2], q_rec.hdr[3]};
				value_n = {q_rec.hdr[4], q_rec.hdr[5]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_rd) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			data_byte     <= q_rec.data_byte;
			byte_index    <= q_rec.byte_index;
			frame_end     <= q_rec.frame_end;
			status        <= q_rec.status;
			slave_id      <= slave_n;
			function_code <= fc_n;
			frame_kind    <= kind_n;
			detail_byte   <= detail_n;
			reg_address   <= addr_n;
			reg_value     <= value_n;
		end
	end

`ifndef SYNTH
	a_drop_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(pop))
		else $error("result dropped without pop");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> $stable(data_byte) && $stable(byte_index))
		else $error("waiting result changed");

	a_fill_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && !q_empty) |-> q_rd)
		else $error("empty output slot not refilled");
`endif

endmodule

// ===== sim/modbus_rtu_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU frame receiver: queue-style handshakes on both sides.
module modbus_rtu_frame_receiver_tb;
	import mrtu_pkg::*;

	localparam int RAND_ITEMS  = 1750;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 20;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_LEN    = 400;
	localparam int DIR_N       = 26;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] byte_index;
		logic             frame_end;
		status_t          status;
		logic [7:0]       slave_id;
		logic [7:0]       function_code;
		kind_t            kind;
		logic [7:0]       detail;
		logic [15:0]      reg_address;
		logic [15:0]      reg_value;
	} rx_result_t;

	typedef enum logic [1:0] {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI, SRC_CRC_BAD} byte_src_t;

	// typed rows carry index, end flag and status; the other decoded fields are zero there
	typedef struct packed {
		byte_src_t        src;
		logic [7:0]       val;
		logic             typed;
		logic             frame_end;
		status_t          status;
		logic [IDX_W-1:0] idx;
	} dir_row_t;

	localparam dir_row_t DIRECTED [0:DIR_N-1] = '{
		// exception frame, extreme slave id and function code
		'{SRC_LIT,     8'h00, 1'b1, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'hFF, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'h01, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_CRC_LO,  8'h00, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_CRC_HI,  8'h00, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		// write coil, address and value at the extremes
		'{SRC_LIT,     8'hFF, 1'b1, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'h05, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'hFF, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'hFF, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'h00, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'h00, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_CRC_LO,  8'h00, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_CRC_HI,  8'h00, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		// unknown code with a broken CRC high byte
		'{SRC_LIT,     8'h7F, 1'b1, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'h2B, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'hAA, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_CRC_LO,  8'h00, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_CRC_BAD, 8'h00, 1'b1, 1'b1, ST_CRC_BAD,  12'd4},
		// read code with zero byte count, good at eight bytes
		'{SRC_LIT,     8'h0A, 1'b1, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'h01, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'h00, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'h12, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'h34, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_LIT,     8'h56, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_CRC_LO,  8'h00, 1'b0, 1'b0, ST_IN_FRAME, 12'd0},
		'{SRC_CRC_HI,  8'h00, 1'b0, 1'b0, ST_IN_FRAME, 12'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        pop = 1'b0;
	logic        full, empty;
	logic [7:0]  data_byte, slave_id, function_code, detail_byte;
	logic [11:0] byte_index;
	logic        frame_end;
	logic [1:0]  status, frame_kind;
	logic [15:0] reg_address, reg_value;

	// predictor state
	logic [FILL_W-1:0] frame_fill;
	logic [15:0]       frame_crc;
	logic [7:0]        frame_hdr [HDR_N];

	rx_result_t results_due [$];
	logic [7:0] frame_bytes [$];

	int mismatches = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int good_frames = 0, bad_frames = 0, overflows = 0;
	int ovf_sent = 0;
	int full_stalls = 0;
	int cycles = 0;
	int burst_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int rx_mode = 0, rx_phase_left = 0;
	logic [15:0] crc_saved = 16'h0000;
	rx_result_t got, want;

	modbus_rtu_frame_receiver uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .rx_byte(rx_byte), .full(full),
		.empty(empty), .pop(pop),
		.data_byte(data_byte), .byte_index(byte_index), .frame_end(frame_end),
		.status(status), .slave_id(slave_id), .function_code(function_code),
		.frame_kind(frame_kind), .detail_byte(detail_byte),
		.reg_address(reg_address), .reg_value(reg_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still due", $time, results_due.size());
			$display("modbus_rtu_frame_receiver verification failed");
			$finish;
		end
	end

	function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
		c ^= {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// advance the frame cutter by one byte and return the result it gives
	function automatic rx_result_t frame_step(logic [7:0] b);
		rx_result_t r;
		logic [7:0] fc;
		int fill;
		bit done;
		r = '0;
		r.data_byte = b;
		r.byte_index = frame_fill[IDX_W-1:0];
		fill = int'(frame_fill);
		if (fill + 1 > MAX_BUFFER) begin
			r.frame_end = 1'b1;
			r.status = ST_OVERFLOW;
			frame_fill = '0;
			frame_crc = CRC_INIT;
			ovf_sent++;
			return r;
		end
		if (fill < HDR_N)
			frame_hdr[fill] = b;
		frame_crc = crc16_next(frame_crc, b);
		fill++;
		frame_fill = FILL_W'(fill);
		if (fill < LEN_SHORT)
			return r;
		fc = frame_hdr[1];
		if ((fc & FC_EXC_MASK) != 8'h00)
			done = (fill == LEN_SHORT);
		else if (fc inside {FC_WRITE_COIL, FC_WRITE_REG})
			done = (fill == LEN_FIXED);
		else if (fc inside {[FC_READ_FIRST:FC_READ_LAST]})
			done = (fill == LEN_FIXED && frame_crc == 16'h0000) ||
				(frame_hdr[2] != 8'h00 && fill == int'(frame_hdr[2]) + 5);
		else
			done = (fill == LEN_SHORT);
		if (!done)
			return r;
		r.frame_end = 1'b1;
		if (frame_crc == 16'h0000) begin
			r.status = ST_GOOD;
			r.slave_id = frame_hdr[0];
			r.function_code = fc;
			// read-code test precedes the length test, so an 8-byte read stays KIND_READ
			if ((fc & FC_EXC_MASK) != 8'h00) begin
				r.kind = KIND_EXC;
				r.detail = frame_hdr[2];
			end else if (fc inside {[FC_READ_FIRST:FC_READ_LAST]}) begin
				r.kind = KIND_READ;
				r.detail = frame_hdr[2];
			end else if (fill == LEN_FIXED) begin
				r.kind = KIND_ADDR;
				r.reg_address = {frame_hdr[2], frame_hdr[3]};
				r.reg_value = {frame_hdr[4], frame_hdr[5]};
			end
		end else begin
			r.status = ST_CRC_BAD;
		end
		frame_fill = '0;
		frame_crc = CRC_INIT;
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit use_typed, input rx_result_t typed);
		rx_result_t pred;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		pred = frame_step(b);
		results_due.push_back(use_typed ? typed : pred);
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full) begin
			full_stalls++;
			@(posedge clk);
		end
		items_accepted++;
	endtask

	task automatic send_plain(input logic [7:0] b);
		send_byte(b, 1'b0, '0);
	endtask

	// finish whatever frame the block is holding with random bytes
	task automatic resync();
		while (frame_fill != '0)
			send_plain(8'($urandom_range(0, 255)));
	endtask

	task automatic random_frame();
		int pick, n, k;
		logic [15:0] c;
		frame_bytes.delete();
		pick = $urandom_range(0, 99);
		frame_bytes.push_back(8'($urandom_range(0, 255)));
		if (pick < 12) begin
			frame_bytes.push_back(FC_EXC_MASK | 8'($urandom_range(0, 127)));
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 20) begin
			n = $urandom_range(0, 121);
			frame_bytes.push_back((n == 0) ? 8'h00 : 8'(n + 6));
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 40) begin
			frame_bytes.push_back($urandom_range(0, 1) ? FC_WRITE_REG : FC_WRITE_COIL);
			repeat (4) frame_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 65) begin
			frame_bytes.push_back(FC_READ_FIRST + 8'($urandom_range(0, 3)));
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
			frame_bytes.push_back(8'(n));
			repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			// zero byte count, only the 8-byte CRC can end it
			frame_bytes.push_back(FC_READ_FIRST + 8'($urandom_range(0, 3)));
			frame_bytes.push_back(8'h00);
			repeat (3) frame_bytes.push_back(8'($urandom_range(0, 255)));
		end
		c = CRC_INIT;
		foreach (frame_bytes[i])
			c = crc16_next(c, frame_bytes[i]);
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
		// a broken zero-count frame would run on to overflow, so those stay intact
		if (pick < 65 && $urandom_range(0, 5) == 0) begin
			k = $urandom_range(0, frame_bytes.size() - 1);
			frame_bytes[k] ^= 8'(1 << $urandom_range(0, 7));
		end
		foreach (frame_bytes[i])
			send_plain(frame_bytes[i]);
	endtask

	function automatic void cmp_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	// result side: check every popped item, then pick the next pop
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				got.data_byte = data_byte;
				got.byte_index = byte_index;
				got.frame_end = frame_end;
				got.status = status_t'(status);
				got.slave_id = slave_id;
				got.function_code = function_code;
				got.kind = kind_t'(frame_kind);
				got.detail = detail_byte;
				got.reg_address = reg_address;
				got.reg_value = reg_value;
				results_checked++;
				if (results_due.size() == 0) begin
					$display("%0t: unexpected item, data %0h index %0d", $time, data_byte, byte_index);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					cmp_field("data_byte", want.data_byte, got.data_byte);
					cmp_field("byte_index", want.byte_index, got.byte_index);
					cmp_field("frame_end", want.frame_end, got.frame_end);
					cmp_field("status", want.status, got.status);
					cmp_field("slave_id", want.slave_id, got.slave_id);
					cmp_field("function_code", want.function_code, got.function_code);
					cmp_field("frame_kind", want.kind, got.kind);
					cmp_field("detail_byte", want.detail, got.detail);
					cmp_field("reg_address", want.reg_address, got.reg_address);
					cmp_field("reg_value", want.reg_value, got.reg_value);
					if (want.frame_end) begin
						case (want.status)
							ST_GOOD:     good_frames++;
							ST_CRC_BAD:  bad_frames++;
							ST_OVERFLOW: overflows++;
							default:     ;
						endcase
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!hold_done && items_accepted >= HOLD_AT) begin
				// long hold-off so the queue fills and full backs up the sender
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
				pop <= 1'b0;
			end else begin
				if (rx_phase_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_phase_left = $urandom_range(16, 96);
				end
				rx_phase_left--;
				case (rx_mode)
					0:       pop <= 1'b1;
					1:       pop <= ($urandom_range(0, 3) != 0);
					2:       pop <= ($urandom_range(0, 3) == 0);
					default: pop <= cycles[1];
				endcase
			end
		end
	end

	initial begin
		rx_result_t typed;
		logic [7:0] b;
		frame_fill = '0;
		frame_crc = CRC_INIT;
		foreach (frame_hdr[i])
			frame_hdr[i] = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			case (DIRECTED[i].src)
				SRC_LIT: b = DIRECTED[i].val;
				SRC_CRC_LO: begin
					crc_saved = frame_crc;
					b = crc_saved[7:0];
				end
				SRC_CRC_HI: b = crc_saved[15:8];
				default:    b = ~crc_saved[15:8];
			endcase
			typed = '0;
			typed.data_byte = b;
			typed.byte_index = DIRECTED[i].idx;
			typed.frame_end = DIRECTED[i].frame_end;
			typed.status = DIRECTED[i].status;
			send_byte(b, DIRECTED[i].typed, typed);
		end

		while (items_accepted < DIR_N + RAND_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 10)) send_plain(8'($urandom_range(0, 255)));
			else
				random_frame();
			resync();
		end

		// zero-count read that collects bytes until the buffer overflows, unless one already did
		if (ovf_sent == 0) begin
			send_plain(8'($urandom_range(0, 255)));
			send_plain(FC_READ_FIRST + 8'($urandom_range(0, 3)));
			send_plain(8'h00);
			resync();
		end

		push <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d bytes checked: %0d good frames, %0d CRC mismatches, %0d overflows",
			results_checked, good_frames, bad_frames, overflows);
		$display("input held off by full for %0d cycles, %0d mismatches", full_stalls, mismatches);
		if (mismatches == 0)
			$display("modbus_rtu_frame_receiver verification clean");
		else
			$display("modbus_rtu_frame_receiver verification failed");
		$finish;
	end

endmodule

// ===== modbus_rtu_frame_receiver.f =====
src/mrtu_pkg.sv
src/mrtu_front.sv
src/mrtu_queue.sv
src/mrtu_back.sv
src/modbus_rtu_frame_receiver.sv
sim/modbus_rtu_frame_receiver_tb.sv
